/* sv/btaa_pkg.sv */
`timescale 1ns / 1ps

package btaa_pkg;

	// Default sizing of the address space and the data word
	localparam int ADDR_BITS_DEF = 8;
	localparam int DATA_BITS_DEF = 32;

	// Width and reset value of the active-bits register
	localparam int CFG_W = 4;
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_FIND   = 2'd2,
		OP_FREE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_CLIMB,
		S_DESCEND
	} state_t;

endpackage

/* sv/btaa_ram.sv */
`timescale 1ns / 1ps

module btaa_ram #(
	parameter int WIDTH = 1,
	parameter int AW    = 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [2**AW];

	// Write one entry and read one entry per cycle, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/binary_trie_address_allocator_top.sv */
`timescale 1ns / 1ps

// Find, remove of a free address and find-free on a full space: done after the LOOK state alone.
// Insert and remove of a taken address: LOOK, then CLIMB from leaf to root, one tree level per cycle.
// Find-free: LOOK, then DESCEND down active_bits levels, active_bits clamped into 1..ADDR_BITS.
// The done beat shows in the cycle busy drops and a new start may be taken then; an out-of-range
// address gives its done beat right after accept, busy low.
// Reset clears every node RAM entry in S_CLEAR with busy high; the receiver cannot stall.
module binary_trie_address_allocator_top #(
	parameter int ADDR_BITS = btaa_pkg::ADDR_BITS_DEF,
	parameter int DATA_BITS = btaa_pkg::DATA_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  op,
	input  logic [ADDR_BITS-1:0]        address,
	input  logic [DATA_BITS-1:0]        entry_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [btaa_pkg::CFG_W-1:0]  cfg_data,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [DATA_BITS-1:0]        read_data,
	output logic [ADDR_BITS-1:0]        free_address
);

	localparam int NW    = ADDR_BITS + 1;
	localparam int LVL_W = $clog2(ADDR_BITS + 1);
	localparam logic [NW-1:0] INNER_N = NW'((2**ADDR_BITS) - 1);

	btaa_pkg::state_t  state_q, state_d;
	btaa_pkg::op_t     op_in, op_q;
	btaa_pkg::status_t status_q, status_d;

	logic [btaa_pkg::CFG_W-1:0] cfg_bits_q;
	logic [LVL_W-1:0]           eff_bits, depth, lvl_q;
	logic [NW-1:0]              clr_q;
	logic                       done_q, done_d;

	logic [ADDR_BITS-1:0] addr_q, faddr_q, faddr_d;
	logic [DATA_BITS-1:0] data_q, rdata_q, rdata_d;
	logic [NW-1:0]        node_q, leaf_in, free_root, node_child, sib_n;
	logic [NW-1:0]        parent_n, sib_p, n_sel, sel_child, leaf_off;
	logic                 val_q, pval, in_range;

	logic                 node_we, node_wdata, node_rdata, ent_we;
	logic [NW-1:0]        node_waddr, node_raddr;
	logic [DATA_BITS-1:0] ent_rdata;

	assign op_in     = btaa_pkg::op_t'(op);
	assign busy      = (state_q != btaa_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign done         = done_q;
	assign status       = status_q;
	assign read_data    = rdata_q;
	assign free_address = faddr_q;

	// Clamp the active-bits register into 1..ADDR_BITS
	always_comb begin
		if (cfg_bits_q == '0) begin
			eff_bits = LVL_W'(1);
		end else if (32'(cfg_bits_q) > ADDR_BITS) begin
			eff_bits = LVL_W'(ADDR_BITS);
		end else begin
			eff_bits = LVL_W'(cfg_bits_q);
		end
	end

	// Heap index arithmetic for the node RAM (leaves follow the inner nodes)
	assign in_range   = ((address >> eff_bits) == '0);
	assign leaf_in    = NW'(address) + INNER_N;
	assign depth      = LVL_W'(ADDR_BITS) - eff_bits;
	assign free_root  = (NW'(1) << depth) - NW'(1);
	assign node_child = {node_q[NW-2:0], 1'b0} + NW'(1);
	assign sib_n      = node_q[0] ? node_q + NW'(1) : node_q - NW'(1);
	assign parent_n   = (node_q - NW'(1)) >> 1;
	assign sib_p      = parent_n[0] ? parent_n + NW'(1) : parent_n - NW'(1);
	assign pval       = val_q & node_rdata;
	assign n_sel      = node_q + NW'(node_rdata);
	assign sel_child  = {n_sel[NW-2:0], 1'b0} + NW'(1);
	assign leaf_off   = n_sel - INNER_N;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			btaa_pkg::S_CLEAR: begin
				if (clr_q == '1) state_d = btaa_pkg::S_IDLE;
			end
			btaa_pkg::S_IDLE: begin
				if (start && (op_in == btaa_pkg::OP_FREE || in_range)) begin
					state_d = btaa_pkg::S_LOOK;
				end
			end
			btaa_pkg::S_LOOK: begin
				unique case (op_q)
					btaa_pkg::OP_INSERT: state_d = btaa_pkg::S_CLIMB;
					btaa_pkg::OP_REMOVE: begin
						state_d = node_rdata ? btaa_pkg::S_CLIMB : btaa_pkg::S_IDLE;
					end
					btaa_pkg::OP_FREE: begin
						state_d = node_rdata ? btaa_pkg::S_IDLE : btaa_pkg::S_DESCEND;
					end
					default: state_d = btaa_pkg::S_IDLE;
				endcase
			end
			btaa_pkg::S_CLIMB: begin
				if (parent_n == '0) state_d = btaa_pkg::S_IDLE;
			end
			btaa_pkg::S_DESCEND: begin
				if (lvl_q == eff_bits) state_d = btaa_pkg::S_IDLE;
			end
			default: state_d = btaa_pkg::S_IDLE;
		endcase
	end

	// RAM ports and result beat
	always_comb begin
		node_raddr = node_q;
		node_we    = 1'b0;
		node_waddr = node_q;
		node_wdata = 1'b0;
		ent_we     = 1'b0;
		done_d     = 1'b0;
		status_d   = btaa_pkg::ST_OK;
		rdata_d    = '0;
		faddr_d    = '0;
		unique case (state_q)
			btaa_pkg::S_CLEAR: begin
				node_we    = 1'b1;
				node_waddr = clr_q;
			end
			btaa_pkg::S_IDLE: begin
				node_raddr = (op_in == btaa_pkg::OP_FREE) ? free_root : leaf_in;
				if (start && op_in != btaa_pkg::OP_FREE && !in_range) begin
					done_d   = 1'b1;
					status_d = btaa_pkg::ST_RANGE;
				end
			end
			btaa_pkg::S_LOOK: begin
				unique case (op_q)
					btaa_pkg::OP_INSERT: begin
						node_we    = 1'b1;
						node_wdata = 1'b1;
						node_raddr = sib_n;
						ent_we     = 1'b1;
					end
					btaa_pkg::OP_REMOVE: begin
						if (node_rdata) begin
							node_we    = 1'b1;
							node_raddr = sib_n;
						end else begin
							done_d   = 1'b1;
							status_d = btaa_pkg::ST_NOT_FOUND;
						end
					end
					btaa_pkg::OP_FIND: begin
						done_d = 1'b1;
						if (node_rdata) begin
							rdata_d = ent_rdata;
						end else begin
							status_d = btaa_pkg::ST_NOT_FOUND;
						end
					end
					default: begin
						node_raddr = node_child;
						if (node_rdata) begin
							done_d   = 1'b1;
							status_d = btaa_pkg::ST_FULL;
						end
					end
				endcase
			end
			btaa_pkg::S_CLIMB: begin
				node_we    = 1'b1;
				node_waddr = parent_n;
				node_wdata = pval;
				node_raddr = sib_p;
				if (parent_n == '0) done_d = 1'b1;
			end
			btaa_pkg::S_DESCEND: begin
				node_raddr = sel_child;
				if (lvl_q == eff_bits) begin
					done_d  = 1'b1;
					faddr_d = leaf_off[ADDR_BITS-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= btaa_pkg::S_CLEAR;
			clr_q      <= '0;
			done_q     <= 1'b0;
			lvl_q      <= '0;
			cfg_bits_q <= btaa_pkg::CFG_RESET;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (state_q == btaa_pkg::S_CLEAR) clr_q <= clr_q + NW'(1);
			if (state_q == btaa_pkg::S_LOOK) begin
				lvl_q <= LVL_W'(1);
			end else if (state_q == btaa_pkg::S_DESCEND) begin
				lvl_q <= lvl_q + LVL_W'(1);
			end
			if (cfg_valid && cfg_ready) cfg_bits_q <= cfg_data;
		end
	end

	// Hold the item and walk the tree
	always_ff @(posedge clk) begin
		unique case (state_q)
			btaa_pkg::S_IDLE: begin
				if (start) begin
					op_q   <= op_in;
					addr_q <= address;
					data_q <= entry_data;
					node_q <= (op_in == btaa_pkg::OP_FREE) ? free_root : leaf_in;
				end
			end
			btaa_pkg::S_LOOK: begin
				val_q <= (op_q == btaa_pkg::OP_INSERT);
				if (op_q == btaa_pkg::OP_FREE) node_q <= node_child;
			end
			btaa_pkg::S_CLIMB: begin
				node_q <= parent_n;
				val_q  <= pval;
			end
			btaa_pkg::S_DESCEND: begin
				node_q <= sel_child;
			end
			default: begin
			end
		endcase
		if (done_d) begin
			status_q <= status_d;
			rdata_q  <= rdata_d;
			faddr_q  <= faddr_d;
		end
	end

	// Taken bits and full marks, one bit per heap node
	btaa_ram #(
		.WIDTH(1),
		.AW   (NW)
	) u_node_ram (
		.clk  (clk),
		.we   (node_we),
		.waddr(node_waddr),
		.wdata(node_wdata),
		.raddr(node_raddr),
		.rdata(node_rdata)
	);

	// Data word per address
	btaa_ram #(
		.WIDTH(DATA_BITS),
		.AW   (ADDR_BITS)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(addr_q),
		.wdata(data_q),
		.raddr(address),
		.rdata(ent_rdata)
	);

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

	localparam int AW = btaa_pkg::ADDR_BITS_DEF;
	localparam int DW = btaa_pkg::DATA_BITS_DEF;
	localparam int SPACE = 1 << AW;
	localparam int N_FIXED = 7;

	typedef struct {
		btaa_pkg::op_t op;
		logic [AW-1:0] addr;
		logic [DW-1:0] data;
	} alloc_req_t;

	typedef struct {
		btaa_pkg::status_t st;
		logic [DW-1:0]     rdata;
		logic [AW-1:0]     faddr;
	} alloc_resp_t;

	typedef struct {
		bit          is_cfg;
		logic [3:0]  cfg_val;
		alloc_req_t  req;
		bit          typed;
		alloc_resp_t want;
	} script_row_t;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [1:0]                  op;
	logic [AW-1:0]               address;
	logic [DW-1:0]               entry_data;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [btaa_pkg::CFG_W-1:0]  cfg_data;
	logic                        done;
	logic [1:0]                  status;
	logic [DW-1:0]               read_data;
	logic [AW-1:0]               free_address;

	// Shadow of the allocator: taken marks, stored words and the raw register
	bit                 taken_shadow [SPACE];
	logic [DW-1:0]      stored_shadow [SPACE];
	logic [3:0]         active_raw;

	alloc_resp_t        pending_results [$];
	script_row_t        script [$];

	int                 errors;
	int                 items_sent;
	int                 results_seen;
	int                 cfg_writes;
	int                 full_seen;
	int                 range_seen;
	int                 missing_seen;

	int fix_bits [N_FIXED] = '{8, 3, 1, 0, 15, 4, 8};
	int fix_len  [N_FIXED] = '{400, 150, 100, 80, 250, 150, 200};
	int fix_fill [N_FIXED] = '{80, 40, 30, 30, 10, 50, 30};

	binary_trie_address_allocator_top #(
		.ADDR_BITS(AW),
		.DATA_BITS(DW)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.address     (address),
		.entry_data  (entry_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.status      (status),
		.read_data   (read_data),
		.free_address(free_address)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Clamp the raw register to the usable trie height
	function automatic int active_height();
		if (active_raw == 4'd0) return 1;
		if (active_raw > AW) return AW;
		return int'(active_raw);
	endfunction

	// Lowest free address in the active space, -1 when every one is taken
	function automatic int lowest_free();
		int span;
		span = 1 << active_height();
		for (int i = 0; i < span; i++) begin
			if (!taken_shadow[i]) return i;
		end
		return -1;
	endfunction

	// Apply one operation to the shadow state and return its result
	function automatic alloc_resp_t allocator_predict(btaa_pkg::op_t o, logic [AW-1:0] a,
			logic [DW-1:0] d);
		alloc_resp_t r;
		int span;
		int lf;
		r.st = btaa_pkg::ST_OK;
		r.rdata = '0;
		r.faddr = '0;
		span = 1 << active_height();
		if (o == btaa_pkg::OP_FREE) begin
			lf = lowest_free();
			if (lf < 0) r.st = btaa_pkg::ST_FULL;
			else r.faddr = AW'(lf);
		end else if (int'(a) >= span) begin
			r.st = btaa_pkg::ST_RANGE;
		end else begin
			case (o)
				btaa_pkg::OP_INSERT: begin
					taken_shadow[a] = 1'b1;
					stored_shadow[a] = d;
				end
				btaa_pkg::OP_REMOVE: begin
					if (taken_shadow[a]) taken_shadow[a] = 1'b0;
					else r.st = btaa_pkg::ST_NOT_FOUND;
				end
				default: begin
					if (taken_shadow[a]) r.rdata = stored_shadow[a];
					else r.st = btaa_pkg::ST_NOT_FOUND;
				end
			endcase
		end
		return r;
	endfunction

	task automatic flag_mismatch(string msg);
		$display("mismatch @%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic add_row(btaa_pkg::op_t o, int a, logic [DW-1:0] d, bit typed = 0,
			btaa_pkg::status_t st = btaa_pkg::ST_OK, logic [DW-1:0] rd = '0, int fa = 0);
		script_row_t row;
		row.is_cfg = 0;
		row.cfg_val = '0;
		row.req.op = o;
		row.req.addr = AW'(a);
		row.req.data = d;
		row.typed = typed;
		row.want.st = st;
		row.want.rdata = rd;
		row.want.faddr = AW'(fa);
		script.push_back(row);
	endtask

	task automatic add_cfg(logic [3:0] v);
		script_row_t row;
		row.is_cfg = 1;
		row.cfg_val = v;
		row.req.op = btaa_pkg::OP_INSERT;
		row.req.addr = '0;
		row.req.data = '0;
		row.typed = 0;
		row.want.st = btaa_pkg::ST_OK;
		row.want.rdata = '0;
		row.want.faddr = '0;
		script.push_back(row);
	endtask

	// Hold start high until the block takes the beat, then log the expectation
	task automatic issue(btaa_pkg::op_t o, logic [AW-1:0] a, logic [DW-1:0] d, bit typed,
			alloc_resp_t want);
		alloc_resp_t got;
		start <= 1'b1;
		op <= o;
		address <= a;
		entry_data <= d;
		do @(posedge clk); while (busy);
		got = allocator_predict(o, a, d);
		pending_results.push_back(typed ? want : got);
		items_sent++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Drop start for a random gap (none when quiet), scrambling the idle payload
	task automatic idle_gap(bit quiet);
		int g;
		g = quiet ? 0 : pick_gap();
		if (g > 0) begin
			start <= 1'b0;
			op <= 2'($urandom);
			address <= AW'($urandom);
			entry_data <= $urandom;
			repeat (g) @(posedge clk);
		end
	endtask

	// Drain all results, let the last update walk finish, then write the register
	task automatic write_active_bits(logic [3:0] v);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (AW + 4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_data <= 4'($urandom);
		active_raw = v;
		cfg_writes++;
	endtask

	// Check every done beat against the oldest expectation
	always @(posedge clk) begin : result_check
		alloc_resp_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("result with nothing pending, status %0d", status));
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				if (want.st == btaa_pkg::ST_FULL) full_seen++;
				if (want.st == btaa_pkg::ST_RANGE) range_seen++;
				if (want.st == btaa_pkg::ST_NOT_FOUND) missing_seen++;
				if (status !== want.st)
					flag_mismatch($sformatf("status %0d, want %0d", status, want.st));
				if (read_data !== want.rdata)
					flag_mismatch($sformatf("read_data %h, want %h", read_data, want.rdata));
				if (free_address !== want.faddr)
					flag_mismatch($sformatf("free_address %0d, want %0d",
						free_address, want.faddr));
			end
		end
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d results pending", pending_results.size());
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		alloc_resp_t   none;
		int            bits;
		int            len;
		int            fill;
		int            span;
		int            r;
		int            lf;
		bit            quiet;
		btaa_pkg::op_t o;
		logic [AW-1:0] a;
		logic [DW-1:0] d;

		none = '{st: btaa_pkg::ST_OK, rdata: '0, faddr: '0};
		arst_n <= 1'b0;
		start <= 1'b0;
		op <= btaa_pkg::OP_INSERT;
		address <= '0;
		entry_data <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		active_raw = btaa_pkg::CFG_RESET;
		foreach (taken_shadow[i]) taken_shadow[i] = 1'b0;
		foreach (stored_shadow[i]) stored_shadow[i] = '0;
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		cfg_writes = 0;
		full_seen = 0;
		range_seen = 0;
		missing_seen = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: empty space, extremes, replace, tiny and clamped heights
		add_row(btaa_pkg::OP_FIND, 0, '0, 1, btaa_pkg::ST_NOT_FOUND);
		add_row(btaa_pkg::OP_FREE, 0, '0, 1, btaa_pkg::ST_OK, '0, 0);
		add_row(btaa_pkg::OP_REMOVE, 255, '0, 1, btaa_pkg::ST_NOT_FOUND);
		add_row(btaa_pkg::OP_INSERT, 0, 32'hFFFF_FFFF, 1, btaa_pkg::ST_OK);
		add_row(btaa_pkg::OP_INSERT, 255, '0, 1, btaa_pkg::ST_OK);
		add_row(btaa_pkg::OP_FIND, 0, '0, 1, btaa_pkg::ST_OK, 32'hFFFF_FFFF);
		add_row(btaa_pkg::OP_FIND, 255, 32'hFFFF_FFFF, 1, btaa_pkg::ST_OK, '0);
		add_row(btaa_pkg::OP_INSERT, 0, 32'hA5A5_5A5A);
		add_row(btaa_pkg::OP_FIND, 0, '0);
		add_row(btaa_pkg::OP_FREE, 255, '0);
		add_row(btaa_pkg::OP_REMOVE, 0, '0);
		add_row(btaa_pkg::OP_FREE, 0, '0);
		add_cfg(4'd1);
		add_row(btaa_pkg::OP_INSERT, 2, 32'h1234_5678, 1, btaa_pkg::ST_RANGE);
		add_row(btaa_pkg::OP_INSERT, 1, 32'h1234_5678);
		add_row(btaa_pkg::OP_FREE, 0, '0);
		add_row(btaa_pkg::OP_INSERT, 0, 32'h0000_0001);
		add_row(btaa_pkg::OP_FREE, 0, '0, 1, btaa_pkg::ST_FULL);
		add_row(btaa_pkg::OP_FIND, 255, '0, 1, btaa_pkg::ST_RANGE);
		add_cfg(4'd0);
		add_row(btaa_pkg::OP_FREE, 0, '0, 1, btaa_pkg::ST_FULL);
		add_row(btaa_pkg::OP_REMOVE, 1, '0);
		add_row(btaa_pkg::OP_FREE, 0, '0);
		add_cfg(4'd15);
		add_row(btaa_pkg::OP_FIND, 255, '0);
		add_row(btaa_pkg::OP_FREE, 0, '0);
		add_cfg(4'd2);
		add_row(btaa_pkg::OP_FIND, 3, '0, 1, btaa_pkg::ST_NOT_FOUND);
		add_row(btaa_pkg::OP_REMOVE, 4, '0, 1, btaa_pkg::ST_RANGE);

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				write_active_bits(script[i].cfg_val);
			end else begin
				issue(script[i].req.op, script[i].req.addr, script[i].req.data,
					script[i].typed, script[i].want);
				idle_gap(0);
			end
		end

		// Random phases: each picks a height, an allocation bias and an idle style
		for (int p = 0; p < 12; p++) begin
			bits = (p < N_FIXED) ? fix_bits[p] : $urandom_range(0, 15);
			len = (p < N_FIXED) ? fix_len[p] : 80;
			fill = (p < N_FIXED) ? fix_fill[p] : $urandom_range(10, 60);
			quiet = (p % 4 == 2);
			write_active_bits(4'(bits));
			span = 1 << active_height();
			for (int k = 0; k < len; k++) begin
				r = $urandom_range(0, 99);
				d = ($urandom_range(0, 9) == 0) ? {DW{r[0]}} : DW'($urandom);
				lf = lowest_free();
				if (r < fill && lf >= 0) begin
					// Allocate: claim the lowest free address
					o = btaa_pkg::OP_INSERT;
					a = AW'(lf);
				end else begin
					r = $urandom_range(0, 99);
					if (r < 40) o = btaa_pkg::OP_REMOVE;
					else if (r < 70) o = btaa_pkg::OP_FIND;
					else if (r < 90) o = btaa_pkg::OP_FREE;
					else o = btaa_pkg::OP_INSERT;
					r = $urandom_range(0, 99);
					if (r < 85) a = AW'($urandom_range(0, span - 1));
					else if (r < 95) a = AW'($urandom);
					else if (r < 97) a = '0;
					else if (r < 99) a = AW'(span - 1);
					else a = '1;
				end
				issue(o, a, d, 0, none);
				idle_gap(quiet);
			end
		end

		// Drain the results, then keep watching for stray beats
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4 * AW) @(posedge clk);

		$display("ran %0d operations over %0d register writes, %0d results checked",
			items_sent, cfg_writes, results_seen);
		$display("saw %0d space-full, %0d out-of-range and %0d not-found results",
			full_seen, range_seen, missing_seen);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", errors);
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* filelist.f */
sv/btaa_pkg.sv
sv/btaa_ram.sv
sv/binary_trie_address_allocator_top.sv
dv/tb.sv
